/* design/hda_pkg.sv */
package hda_pkg;

    // Timer count width; counts saturate at all ones
    localparam int TIMER_BITS = 16;
    // Width of the tick limit registers
    localparam int LIMIT_BITS = 16;
    // Width at which a count meets a limit
    localparam int CMP_BITS   = (TIMER_BITS > LIMIT_BITS) ? TIMER_BITS : LIMIT_BITS;

    localparam int DIST_BITS  = 10;
    localparam int TEMP_BITS  = 12;
    localparam int CODE_BITS  = 3;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    typedef logic [TIMER_BITS-1:0] count_t;
    typedef logic [LIMIT_BITS-1:0] limit_t;

    // Hangar modes, one-hot
    typedef enum logic [5:0] {
        MODE_INSIDE   = 6'b000001,
        MODE_TAKEOFF  = 6'b000010,
        MODE_OUT      = 6'b000100,
        MODE_LANDING  = 6'b001000,
        MODE_PREALARM = 6'b010000,
        MODE_ALARM    = 6'b100000
    } mode_t;

    // Mode codes as reported on the result channel
    localparam logic [CODE_BITS-1:0] CODE_INSIDE   = 3'd0;
    localparam logic [CODE_BITS-1:0] CODE_TAKEOFF  = 3'd1;
    localparam logic [CODE_BITS-1:0] CODE_OUT      = 3'd2;
    localparam logic [CODE_BITS-1:0] CODE_LANDING  = 3'd3;
    localparam logic [CODE_BITS-1:0] CODE_PREALARM = 3'd4;
    localparam logic [CODE_BITS-1:0] CODE_ALARM    = 3'd5;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_OUT_DISTANCE = 3'd0,
        REG_IN_DISTANCE  = 3'd1,
        REG_HEAT_LIMIT   = 3'd2,
        REG_OUT_HOLD     = 3'd3,
        REG_IN_HOLD      = 3'd4,
        REG_PREALARM     = 3'd5,
        REG_ALARM        = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic        [DIST_BITS-1:0] out_distance_cm;
        logic        [DIST_BITS-1:0] in_distance_cm;
        logic signed [TEMP_BITS-1:0] heat_limit;
        limit_t                      out_hold_ticks;
        limit_t                      in_hold_ticks;
        limit_t                      prealarm_ticks;
        limit_t                      alarm_ticks;
    } cfg_t;

    typedef struct packed {
        logic   running;
        count_t count;
    } timer_t;

    typedef struct packed {
        timer_t tmr;
        logic   expired;
    } timer_step_t;

    function automatic logic [CODE_BITS-1:0] mode_code(mode_t m);
        logic [CODE_BITS-1:0] c;
        unique case (m)
            MODE_INSIDE:   c = CODE_INSIDE;
            MODE_TAKEOFF:  c = CODE_TAKEOFF;
            MODE_OUT:      c = CODE_OUT;
            MODE_LANDING:  c = CODE_LANDING;
            MODE_PREALARM: c = CODE_PREALARM;
            MODE_ALARM:    c = CODE_ALARM;
            default:       c = CODE_INSIDE;
        endcase
        return c;
    endfunction

    // Advance a running timer by one tick, saturating
    function automatic timer_t timer_advance(timer_t t);
        timer_t r;
        r = t;
        if (t.running && (t.count != {TIMER_BITS{1'b1}})) begin
            r.count = t.count + count_t'(1);
        end
        return r;
    endfunction

    // A limit wider than the count never expires once the count saturates
    function automatic logic count_reached(count_t c, limit_t lim);
        return CMP_BITS'(c) >= CMP_BITS'(lim);
    endfunction

    // Hold timer: start on condition, clear when it drops, flag at the limit
    function automatic timer_step_t hold_step(timer_t t, logic cond, limit_t lim);
        timer_step_t r;
        r.tmr     = t;
        r.expired = 1'b0;
        if (cond && !t.running) begin
            r.tmr.running = 1'b1;
            r.tmr.count   = '0;
        end else if (!cond) begin
            r.tmr.running = 1'b0;
            r.tmr.count   = '0;
        end else begin
            r.expired = count_reached(t.count, lim);
        end
        return r;
    endfunction

    // Heat timer: as the hold timer, but restarts when it expires
    function automatic timer_step_t heat_step(timer_t t, logic hot, limit_t lim);
        timer_step_t r;
        r.tmr     = t;
        r.expired = 1'b0;
        if (hot && !t.running) begin
            r.tmr.running = 1'b1;
            r.tmr.count   = '0;
        end else if (!hot) begin
            r.tmr.running = 1'b0;
            r.tmr.count   = '0;
        end else if (count_reached(t.count, lim)) begin
            r.tmr.running = 1'b1;
            r.tmr.count   = '0;
            r.expired     = 1'b1;
        end
        return r;
    endfunction

endpackage

/* design/hangar_door_alarm_fsm_core.sv */
// Hangar door and heat alarm controller. Each input beat is one millisecond tick
// carrying distance, temperature, command pulses, presence and the acknowledge
// button; each accepted beat yields exactly one result beat with the mode, door,
// lamp levels and the alarm raised/cleared pulses. A beat can be accepted on every
// clock while results are taken: the tick update is one pass of compare and select
// logic from the state registers to the result register, so a result is registered
// when its beat is accepted, and a new beat is taken while the previous result is
// being taken downstream. The user writes configuration through the plain write
// port while the block is idle (not enforced); no clearing pass follows reset.
module hangar_door_alarm_fsm_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [9:0] distance_cm, [21:10] temperature, [22] takeoff_request,
    // [23] land_request, [24] drone_near, [25] alarm_ack, [31:26] zero
    input  logic [31:0]                         s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [2:0] machine_state, [3] door_is_open, [4] inside_lamp, [5] transit_lamp,
    // [6] alarm_lamp, [7] alarm_raised, [8] alarm_cleared, [15:9] zero
    output logic [15:0]                         m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [hda_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [hda_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

    hda_pkg::cfg_t cfg;

    hda_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Input beat fields
    logic        [hda_pkg::DIST_BITS-1:0] dist_cm;
    logic signed [hda_pkg::TEMP_BITS-1:0] temp;
    logic takeoff_req, land_req, drone_near, alarm_ack;

    assign dist_cm     = s_tdata[9:0];
    assign temp        = s_tdata[21:10];
    assign takeoff_req = s_tdata[22];
    assign land_req    = s_tdata[23];
    assign drone_near  = s_tdata[24];
    assign alarm_ack   = s_tdata[25];

    hda_pkg::mode_t  mode_reg, mode_next, prior_reg, prior_next;
    logic            takeoff_pend_reg, takeoff_pend_next;
    logic            land_pend_reg, land_pend_next;
    hda_pkg::timer_t hold_reg, hold_next, heat_reg, heat_next;
    logic            door_reg, door_next;
    logic            inside_lamp_reg, inside_lamp_next;
    logic            alarm_lamp_reg, alarm_lamp_next;
    logic            m_tvalid_reg;
    logic [15:0]     m_tdata_reg, m_tdata_next;

    hda_pkg::timer_step_t hold_res, heat_res;
    logic hot, far, close_in, run_heat, raised, cleared, transit, s_acc;

    assign hot      = temp >= $signed(cfg.heat_limit);
    assign far      = dist_cm >= cfg.out_distance_cm;
    assign close_in = dist_cm <= cfg.in_distance_cm;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;

    // Work out one tick of the hangar machine
    always_comb begin
        mode_next         = mode_reg;
        prior_next        = prior_reg;
        takeoff_pend_next = takeoff_pend_reg | takeoff_req;
        land_pend_next    = land_pend_reg | land_req;
        hold_next         = hda_pkg::timer_advance(hold_reg);
        heat_next         = hda_pkg::timer_advance(heat_reg);
        door_next         = door_reg;
        inside_lamp_next  = inside_lamp_reg;
        alarm_lamp_next   = alarm_lamp_reg;
        raised            = 1'b0;
        cleared           = 1'b0;
        run_heat          = 1'b0;
        hold_res          = '0;
        heat_res          = '0;

        unique case (mode_reg)
            hda_pkg::MODE_INSIDE: begin
                if (takeoff_pend_next) begin
                    takeoff_pend_next = 1'b0;
                    inside_lamp_next  = 1'b0;
                    door_next         = 1'b1;
                    hold_next         = '0;
                    mode_next         = hda_pkg::MODE_TAKEOFF;
                end
                run_heat = 1'b1;
            end
            hda_pkg::MODE_TAKEOFF: begin
                hold_res  = hda_pkg::hold_step(hold_next, far, cfg.out_hold_ticks);
                hold_next = hold_res.tmr;
                if (hold_res.expired) begin
                    door_next      = 1'b0;
                    land_pend_next = 1'b0;
                    mode_next      = hda_pkg::MODE_OUT;
                end
                run_heat = 1'b1;
            end
            hda_pkg::MODE_OUT: begin
                if (land_pend_next && drone_near) begin
                    land_pend_next = 1'b0;
                    door_next      = 1'b1;
                    hold_next      = '0;
                    mode_next      = hda_pkg::MODE_LANDING;
                end
            end
            hda_pkg::MODE_LANDING: begin
                hold_res  = hda_pkg::hold_step(hold_next, close_in, cfg.in_hold_ticks);
                hold_next = hold_res.tmr;
                if (hold_res.expired) begin
                    door_next         = 1'b0;
                    inside_lamp_next  = 1'b1;
                    takeoff_pend_next = 1'b0;
                    mode_next         = hda_pkg::MODE_INSIDE;
                end
                run_heat = 1'b1;
            end
            hda_pkg::MODE_PREALARM: begin
                // Let an interrupted takeoff or landing finish in the background
                if (prior_reg == hda_pkg::MODE_LANDING) begin
                    hold_res  = hda_pkg::hold_step(hold_next, close_in, cfg.in_hold_ticks);
                    hold_next = hold_res.tmr;
                    if (hold_res.expired) begin
                        door_next  = 1'b0;
                        prior_next = hda_pkg::MODE_INSIDE;
                    end
                end else if (prior_reg == hda_pkg::MODE_TAKEOFF) begin
                    hold_res  = hda_pkg::hold_step(hold_next, far, cfg.out_hold_ticks);
                    hold_next = hold_res.tmr;
                    if (hold_res.expired) begin
                        door_next  = 1'b0;
                        prior_next = hda_pkg::MODE_OUT;
                    end
                end
                if (!hot) begin
                    mode_next = prior_next;
                end else if (heat_next.running &&
                             hda_pkg::count_reached(heat_next.count, cfg.alarm_ticks)) begin
                    if (prior_next == hda_pkg::MODE_LANDING) begin
                        prior_next = hda_pkg::MODE_INSIDE;
                    end else if (prior_next == hda_pkg::MODE_TAKEOFF) begin
                        prior_next = hda_pkg::MODE_OUT;
                    end
                    door_next        = 1'b0;
                    alarm_lamp_next  = 1'b1;
                    inside_lamp_next = 1'b0;
                    raised           = 1'b1;
                    mode_next        = hda_pkg::MODE_ALARM;
                end
            end
            hda_pkg::MODE_ALARM: begin
                if (alarm_ack) begin
                    alarm_lamp_next = 1'b0;
                    cleared         = 1'b1;
                    heat_next       = '0;
                    if (prior_reg == hda_pkg::MODE_INSIDE) begin
                        inside_lamp_next = 1'b1;
                    end
                    mode_next = prior_reg;
                end
            end
            default: begin
            end
        endcase

        // Heat watch after the mode update of inside, takeoff and landing
        if (run_heat) begin
            heat_res  = hda_pkg::heat_step(heat_next, hot, cfg.prealarm_ticks);
            heat_next = heat_res.tmr;
            if (heat_res.expired) begin
                if (mode_next == hda_pkg::MODE_INSIDE || mode_next == hda_pkg::MODE_TAKEOFF) begin
                    door_next = 1'b0;
                end
                prior_next = mode_next;
                mode_next  = hda_pkg::MODE_PREALARM;
            end
        end
    end

    assign transit = (mode_next == hda_pkg::MODE_TAKEOFF) ||
                     (mode_next == hda_pkg::MODE_LANDING);

    assign m_tdata_next = {7'b0, cleared, raised, alarm_lamp_next, transit,
                           inside_lamp_next, door_next, hda_pkg::mode_code(mode_next)};

    // Commit the tick on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= hda_pkg::MODE_INSIDE;
            prior_reg        <= hda_pkg::MODE_INSIDE;
            takeoff_pend_reg <= 1'b0;
            land_pend_reg    <= 1'b0;
            hold_reg         <= '0;
            heat_reg         <= '0;
            door_reg         <= 1'b0;
            inside_lamp_reg  <= 1'b1;
            alarm_lamp_reg   <= 1'b0;
        end else if (s_acc) begin
            mode_reg         <= mode_next;
            prior_reg        <= prior_next;
            takeoff_pend_reg <= takeoff_pend_next;
            land_pend_reg    <= land_pend_next;
            hold_reg         <= hold_next;
            heat_reg         <= heat_next;
            door_reg         <= door_next;
            inside_lamp_reg  <= inside_lamp_next;
            alarm_lamp_reg   <= alarm_lamp_next;
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_acc) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> m_tvalid_reg)
        else $error("accepted beat produced no result");

    a_raise_enters_alarm: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && raised) |=> (mode_reg == hda_pkg::MODE_ALARM))
        else $error("alarm raised without entering alarm");

    a_lamp_tracks_alarm: assert property (@(posedge aclk) disable iff (!aresetn)
        alarm_lamp_reg == (mode_reg == hda_pkg::MODE_ALARM))
        else $error("alarm lamp out of step with alarm mode");

    a_door_open_modes: assert property (@(posedge aclk) disable iff (!aresetn)
        door_reg |-> (mode_reg == hda_pkg::MODE_TAKEOFF ||
                      mode_reg == hda_pkg::MODE_LANDING ||
                      mode_reg == hda_pkg::MODE_PREALARM))
        else $error("door open in a closed-door mode");
`endif

endmodule

/* design/hda_cfg.sv */
module hda_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [hda_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [hda_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
    output hda_pkg::cfg_t                       cfg
);

    hda_pkg::cfg_t cfg_reg;

    // Load defaults on reset, take one register per write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.out_distance_cm <= hda_pkg::DIST_BITS'(100);
            cfg_reg.in_distance_cm  <= hda_pkg::DIST_BITS'(20);
            cfg_reg.heat_limit      <= hda_pkg::TEMP_BITS'(400);
            cfg_reg.out_hold_ticks  <= hda_pkg::LIMIT_BITS'(3000);
            cfg_reg.in_hold_ticks   <= hda_pkg::LIMIT_BITS'(3000);
            cfg_reg.prealarm_ticks  <= hda_pkg::LIMIT_BITS'(5000);
            cfg_reg.alarm_ticks     <= hda_pkg::LIMIT_BITS'(5000);
        end else if (cfg_wr_en) begin
            unique case (hda_pkg::reg_index_t'(cfg_index))
                hda_pkg::REG_OUT_DISTANCE:
                    cfg_reg.out_distance_cm <= cfg_wdata[hda_pkg::DIST_BITS-1:0];
                hda_pkg::REG_IN_DISTANCE:
                    cfg_reg.in_distance_cm  <= cfg_wdata[hda_pkg::DIST_BITS-1:0];
                hda_pkg::REG_HEAT_LIMIT:
                    cfg_reg.heat_limit      <= cfg_wdata[hda_pkg::TEMP_BITS-1:0];
                hda_pkg::REG_OUT_HOLD:
                    cfg_reg.out_hold_ticks  <= cfg_wdata[hda_pkg::LIMIT_BITS-1:0];
                hda_pkg::REG_IN_HOLD:
                    cfg_reg.in_hold_ticks   <= cfg_wdata[hda_pkg::LIMIT_BITS-1:0];
                hda_pkg::REG_PREALARM:
                    cfg_reg.prealarm_ticks  <= cfg_wdata[hda_pkg::LIMIT_BITS-1:0];
                hda_pkg::REG_ALARM:
                    cfg_reg.alarm_ticks     <= cfg_wdata[hda_pkg::LIMIT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* test/hda_checker.sv */
module hda_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    // [9:0] distance_cm, [21:10] temperature, [22] takeoff_request,
    // [23] land_request, [24] drone_near, [25] alarm_ack, [31:26] zero
    input  logic [31:0]                       s_tdata,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    // [2:0] machine_state, [3] door_is_open, [4] inside_lamp, [5] transit_lamp,
    // [6] alarm_lamp, [7] alarm_raised, [8] alarm_cleared, [15:9] zero
    input  logic [15:0]                       m_tdata,
    input  logic                              cfg_wr_en,
    input  logic [hda_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [hda_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
    output int                                outstanding,
    output int                                fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import hda_pkg::*;

    // Hangar status as carried on the result channel, lowest field last
    typedef struct packed {
        logic                 cleared;
        logic                 raised;
        logic                 alarm_lamp;
        logic                 transit_lamp;
        logic                 inside_lamp;
        logic                 door_open;
        logic [CODE_BITS-1:0] mode;
    } hangar_status_t;

    // Shadow copy of the controller state and its limits
    cfg_t                 limits;
    logic [CODE_BITS-1:0] mode;
    logic [CODE_BITS-1:0] resume_mode;
    logic                 takeoff_pend;
    logic                 land_pend;
    logic                 hold_run;
    count_t               hold_cnt;
    logic                 heat_run;
    count_t               heat_cnt;
    logic                 door_open;
    logic                 inside_lamp;
    logic                 alarm_lamp;

    hangar_status_t       status_fifo[$];

    // Distance hold timer: arm on condition, clear when it drops, report expiry
    function automatic logic hold_elapsed(logic cond, limit_t lim);
        if (cond && !hold_run) begin
            hold_run = 1'b1;
            hold_cnt = '0;
        end else if (!cond) begin
            hold_run = 1'b0;
            hold_cnt = '0;
        end else if (hold_cnt >= lim) begin
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Heat timer: arm when hot, clear when cool, enter prealarm on expiry
    function automatic void heat_watch(logic signed [TEMP_BITS-1:0] temp);
        logic hot;
        hot = $signed(temp) >= $signed(limits.heat_limit);
        if (hot && !heat_run) begin
            heat_run = 1'b1;
            heat_cnt = '0;
        end else if (!hot) begin
            heat_run = 1'b0;
            heat_cnt = '0;
        end else if (heat_cnt >= limits.prealarm_ticks) begin
            if (mode == CODE_INSIDE || mode == CODE_TAKEOFF) begin
                door_open = 1'b0;
            end
            resume_mode = mode;
            heat_run    = 1'b1;
            heat_cnt    = '0;
            mode        = CODE_PREALARM;
        end
    endfunction

    // Advance the shadow state by one tick and return the status it yields
    function automatic hangar_status_t hangar_tick(logic [31:0] beat);
        logic [DIST_BITS-1:0]        dist_cm;
        logic signed [TEMP_BITS-1:0] temp;
        logic                        near;
        logic                        ack;
        logic                        hot;
        hangar_status_t              r;
        dist_cm = beat[9:0];
        temp    = beat[21:10];
        near    = beat[24];
        ack     = beat[25];
        hot     = $signed(temp) >= $signed(limits.heat_limit);
        r       = '0;

        // Latch command pulses before the mode logic sees them
        if (beat[22]) takeoff_pend = 1'b1;
        if (beat[23]) land_pend = 1'b1;

        // Advance running timers, holding at all ones
        if (hold_run && hold_cnt != '1) hold_cnt = hold_cnt + 1'b1;
        if (heat_run && heat_cnt != '1) heat_cnt = heat_cnt + 1'b1;

        case (mode)
            CODE_INSIDE: begin
                if (takeoff_pend) begin
                    takeoff_pend = 1'b0;
                    inside_lamp  = 1'b0;
                    door_open    = 1'b1;
                    hold_run     = 1'b0;
                    hold_cnt     = '0;
                    mode         = CODE_TAKEOFF;
                end
                heat_watch(temp);
            end
            CODE_TAKEOFF: begin
                if (hold_elapsed(dist_cm >= limits.out_distance_cm, limits.out_hold_ticks)) begin
                    door_open = 1'b0;
                    land_pend = 1'b0;
                    mode      = CODE_OUT;
                end
                heat_watch(temp);
            end
            CODE_OUT: begin
                if (land_pend && near) begin
                    land_pend = 1'b0;
                    door_open = 1'b1;
                    hold_run  = 1'b0;
                    hold_cnt  = '0;
                    mode      = CODE_LANDING;
                end
            end
            CODE_LANDING: begin
                if (hold_elapsed(dist_cm <= limits.in_distance_cm, limits.in_hold_ticks)) begin
                    door_open    = 1'b0;
                    inside_lamp  = 1'b1;
                    takeoff_pend = 1'b0;
                    mode         = CODE_INSIDE;
                end
                heat_watch(temp);
            end
            CODE_PREALARM: begin
                // Let an interrupted takeoff or landing finish in the background
                if (resume_mode == CODE_LANDING) begin
                    if (hold_elapsed(dist_cm <= limits.in_distance_cm,
                                     limits.in_hold_ticks)) begin
                        door_open   = 1'b0;
                        resume_mode = CODE_INSIDE;
                    end
                end else if (resume_mode == CODE_TAKEOFF) begin
                    if (hold_elapsed(dist_cm >= limits.out_distance_cm,
                                     limits.out_hold_ticks)) begin
                        door_open   = 1'b0;
                        resume_mode = CODE_OUT;
                    end
                end
                if (!hot) begin
                    mode = resume_mode;
                end else if (heat_run && heat_cnt >= limits.alarm_ticks) begin
                    if (resume_mode == CODE_LANDING) begin
                        resume_mode = CODE_INSIDE;
                    end else if (resume_mode == CODE_TAKEOFF) begin
                        resume_mode = CODE_OUT;
                    end
                    door_open   = 1'b0;
                    alarm_lamp  = 1'b1;
                    inside_lamp = 1'b0;
                    r.raised    = 1'b1;
                    mode        = CODE_ALARM;
                end
            end
            CODE_ALARM: begin
                if (ack) begin
                    alarm_lamp = 1'b0;
                    r.cleared  = 1'b1;
                    heat_run   = 1'b0;
                    heat_cnt   = '0;
                    if (resume_mode == CODE_INSIDE) inside_lamp = 1'b1;
                    mode = resume_mode;
                end
            end
            default: begin
            end
        endcase

        r.mode         = mode;
        r.door_open    = door_open;
        r.inside_lamp  = inside_lamp;
        r.transit_lamp = (mode == CODE_TAKEOFF) || (mode == CODE_LANDING);
        r.alarm_lamp   = alarm_lamp;
        return r;
    endfunction

    // Count a mismatch, report only the first few
    task automatic log_mismatch(string msg);
        fail_count++;
        if (fail_count <= 10) $display("%0t mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            log_mismatch($sformatf("%s expected %0d got %0d", field, want, got));
        end
    endtask

    initial fail_count = 0;

    // Watch both channels and the register port on every rising edge
    always @(posedge aclk) begin : watch
        hangar_status_t got;
        hangar_status_t want;
        if (!aresetn) begin
            limits.out_distance_cm = 10'd100;
            limits.in_distance_cm  = 10'd20;
            limits.heat_limit      = 12'sd400;
            limits.out_hold_ticks  = 16'd3000;
            limits.in_hold_ticks   = 16'd3000;
            limits.prealarm_ticks  = 16'd5000;
            limits.alarm_ticks     = 16'd5000;
            mode         = CODE_INSIDE;
            resume_mode  = CODE_INSIDE;
            takeoff_pend = 1'b0;
            land_pend    = 1'b0;
            hold_run     = 1'b0;
            hold_cnt     = '0;
            heat_run     = 1'b0;
            heat_cnt     = '0;
            door_open    = 1'b0;
            inside_lamp  = 1'b1;
            alarm_lamp   = 1'b0;
            status_fifo.delete();
            outstanding <= 0;
        end else begin
            // Compare a delivered status beat with the oldest prediction
            if (m_tvalid && m_tready) begin
                got = hangar_status_t'(m_tdata[8:0]);
                if (status_fifo.size() == 0) begin
                    log_mismatch($sformatf("status beat 0x%03h with nothing expected",
                                           m_tdata));
                end else begin
                    want = status_fifo.pop_front();
                    check_field("machine_state", want.mode, got.mode);
                    check_field("door_is_open", want.door_open, got.door_open);
                    check_field("inside_lamp", want.inside_lamp, got.inside_lamp);
                    check_field("transit_lamp", want.transit_lamp, got.transit_lamp);
                    check_field("alarm_lamp", want.alarm_lamp, got.alarm_lamp);
                    check_field("alarm_raised", want.raised, got.raised);
                    check_field("alarm_cleared", want.cleared, got.cleared);
                end
            end

            // Track register writes; unused indexes are dropped
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_OUT_DISTANCE: limits.out_distance_cm = cfg_wdata[DIST_BITS-1:0];
                    REG_IN_DISTANCE:  limits.in_distance_cm  = cfg_wdata[DIST_BITS-1:0];
                    REG_HEAT_LIMIT:   limits.heat_limit      = cfg_wdata[TEMP_BITS-1:0];
                    REG_OUT_HOLD:     limits.out_hold_ticks  = cfg_wdata;
                    REG_IN_HOLD:      limits.in_hold_ticks   = cfg_wdata;
                    REG_PREALARM:     limits.prealarm_ticks  = cfg_wdata;
                    REG_ALARM:        limits.alarm_ticks     = cfg_wdata;
                    default: begin
                    end
                endcase
            end

            // Predict the status for each accepted tick beat
            if (s_tvalid && s_tready) status_fifo.push_back(hangar_tick(s_tdata));

            outstanding <= status_fifo.size();
        end
    end

endmodule

/* test/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hda_pkg::*;

    // Index past the last register, must be ignored
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 3'd7;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [31:0]              s_tdata   = '0;
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [15:0]              m_tdata;
    logic                     cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
    int                       outstanding;
    int                       fail_count;

    // Stimulus view of the current limits
    int far_cm   = 100;
    int near_cm  = 20;
    int heat_lim = 400;

    bit near_zone;
    bit hot_zone;
    bit tx_steady;
    bit rx_steady;
    int rx_hold = 0;

    always #10 aclk = ~aclk;

    hangar_door_alarm_fsm_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    hda_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    // Stall the result side: mostly short stalls, now and then a long one
    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold  <= rx_hold - 1;
            m_tready <= 1'b0;
        end else if (rx_steady || $urandom_range(3) != 0) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= 1'b0;
            rx_hold  <= ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3);
        end
    end

    // Write one register, then drop the enable
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_limits(int far, int near, int heat,
                              int out_hold, int in_hold, int pre, int alarm);
        far_cm   = far;
        near_cm  = near;
        heat_lim = heat;
        write_reg(REG_OUT_DISTANCE, 16'(far));
        write_reg(REG_IN_DISTANCE, 16'(near));
        write_reg(REG_HEAT_LIMIT, 16'(heat));
        write_reg(REG_OUT_HOLD, 16'(out_hold));
        write_reg(REG_IN_HOLD, 16'(in_hold));
        write_reg(REG_PREALARM, 16'(pre));
        write_reg(REG_ALARM, 16'(alarm));
    endtask

    // Hold off the sender until every status beat has come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (3) @(posedge aclk);
    endtask

    // Present one tick beat after an optional gap and wait for its acceptance
    task automatic send_tick(int dist_cm, int temp, bit takeoff, bit land, bit near, bit ack);
        int gap;
        int pick;
        pick = $urandom_range(9);
        if (tx_steady || pick < 5) gap = 0;
        else if (pick < 9) gap = $urandom_range(3, 1);
        else gap = $urandom_range(40, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, ack, near, land, takeoff, 12'(temp), 10'(dist_cm)};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Random tick with distance and heat held in zones so the timers can expire
    task automatic random_tick();
        int dist_cm;
        int temp;
        if ($urandom_range(7) == 0) near_zone = !near_zone;
        if ($urandom_range(11) == 0) hot_zone = !hot_zone;
        if ($urandom_range(19) < 3) dist_cm = $urandom_range(1023);
        else if (near_zone) dist_cm = $urandom_range(near_cm, 0);
        else dist_cm = $urandom_range(1023, far_cm);
        if ($urandom_range(9) == 0) temp = -400 + int'($urandom_range(1650));
        else if (hot_zone || heat_lim == -400) temp = heat_lim + int'($urandom_range(1250 - heat_lim));
        else temp = -400 + int'($urandom_range(heat_lim + 399));
        send_tick(dist_cm, temp, $urandom_range(5) == 0, $urandom_range(5) == 0,
                  1'($urandom_range(1)), $urandom_range(4) == 0);
    endtask

    task automatic run_random(int n);
        tx_steady = ($urandom_range(3) == 0);
        rx_steady = ($urandom_range(3) == 0);
        repeat (n) random_tick();
    endtask

    initial begin
        int far;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Field extremes under the reset limits
        send_tick(0, -400, 0, 0, 0, 0);
        send_tick(1023, 1250, 0, 0, 1, 1);
        wait_idle();

        // Walk every mode with one-tick limits
        set_limits(100, 20, 400, 1, 1, 1, 1);
        send_tick(500, 0, 1, 0, 0, 0);
        send_tick(500, 0, 0, 0, 0, 0);
        send_tick(500, 0, 0, 0, 0, 0);
        send_tick(500, 0, 0, 1, 0, 0);
        send_tick(10, 0, 0, 0, 1, 0);
        send_tick(10, 0, 0, 0, 1, 0);
        send_tick(10, 0, 0, 0, 1, 0);
        send_tick(10, 1250, 0, 0, 0, 0);
        send_tick(10, 1250, 0, 0, 0, 0);
        send_tick(10, 1250, 0, 0, 0, 1);
        send_tick(10, 1250, 0, 0, 0, 0);
        send_tick(10, 1250, 0, 0, 0, 1);
        // Both commands on one tick, then prealarm left by cooling
        send_tick(500, 500, 1, 1, 0, 0);
        send_tick(500, 500, 0, 0, 0, 0);
        send_tick(500, 0, 0, 0, 0, 0);
        send_tick(500, 0, 0, 0, 1, 0);
        send_tick(10, 0, 0, 1, 1, 0);
        send_tick(10, 0, 0, 0, 1, 0);
        wait_idle();

        // Short timers with the usual thresholds; pause once midway
        set_limits(100, 20, 400, 2, 3, 4, 3);
        run_random(60);
        wait_idle();
        run_random(60);
        wait_idle();

        // Low extremes: every condition true, timers expire at once
        set_limits(0, 1023, -400, 0, 0, 0, 0);
        write_reg(REG_SPARE, 16'hFFFF);
        run_random(60);
        wait_idle();

        // High extremes: conditions hardly met, timers never expire here
        set_limits(1023, 0, 1250, 65535, 65535, 65535, 65535);
        run_random(40);
        wait_idle();

        // Random limits
        repeat (3) begin
            far = $urandom_range(600, 50);
            set_limits(far, $urandom_range(far, 0), -400 + int'($urandom_range(1650)),
                       $urandom_range(6), $urandom_range(6),
                       $urandom_range(8), $urandom_range(8));
            run_random(90);
            wait_idle();
        end

        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* files.f */
design/hda_pkg.sv
design/hda_cfg.sv
design/hangar_door_alarm_fsm_core.sv
test/hda_checker.sv
test/tb.sv
